/* design/mmf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mmf_pkg - shared types of the moving median filter
// Compare result of the shared unit and control of the window stores.
// ---------------------------------------------------------------------------
package mmf_pkg;

   // result of one signed compare a against b
   typedef struct packed {
      logic lt;
      logic eq;
   } mmf_cmp_res_type;

   // per-cycle control of the sorted row and the arrival ring
   typedef struct packed {
      logic rotate;     // sorted row moves one place towards the head
      logic ring_push;  // ring drops its oldest sample and takes the new one
   } mmf_win_ctrl_type;

endpackage
`default_nettype wire

/* design/moving_median_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// moving_median_filter - running median over a sliding window
// One sample in, one median out; window stores cleared to zero at reset.
// ---------------------------------------------------------------------------
// Each sample passes from the idle state through two setup compares, a
// sweep with one compare per sorted entry and a state that registers the
// median; only then, back in idle, is the next beat taken. The emit state
// waits while the last median has not been taken. The sweep moves the sorted
// row through the single shared compare unit, one entry per cycle. The oldest sample is
// dropped from the sorted row and the new one merged in during that sweep;
// the median is the middle sorted entry. Until WINDOW samples have arrived
// the zeros held since reset take part in the median.
module moving_median_filter #(
   parameter int WINDOW      = 5,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // fields from bit 0: sample
   input  wire logic [8*((SAMPLE_BITS+7)/8)-1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // fields from bit 0: median
   output logic [8*((SAMPLE_BITS+7)/8)-1:0]      rsp_tdata
);
   import mmf_pkg::*;

   localparam int TDATA_BITS = 8 * ((SAMPLE_BITS + 7) / 8);
   localparam int CNT_BITS   = $clog2(WINDOW);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIR,
      ST_HEAD,
      ST_SWEEP,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_PRE,
      PH_SHIFT,
      PH_POST
   } phase_type;

   state_type                     state_ff, state_in;
   phase_type                     phase_ff, phase_in;
   logic                          up_ff, up_in;
   logic [CNT_BITS-1:0]           k_ff, k_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0] carry_ff, carry_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   mmf_win_ctrl_type              win_ctrl;
   logic signed [SAMPLE_BITS-1:0] sort_tail;
   logic signed [SAMPLE_BITS-1:0] head, next, oldest, mid;
   logic signed [SAMPLE_BITS-1:0] cmp_a, cmp_b;
   mmf_cmp_res_type               cmp_res;
   logic                          last;

   mmf_window #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (win_ctrl),
      .sort_tail (sort_tail),
      .ring_tail (x_ff),
      .head      (head),
      .next      (next),
      .oldest    (oldest),
      .mid       (mid)
   );

   mmf_cmp #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_cmp (
      .a   (cmp_a),
      .b   (cmp_b),
      .res (cmp_res)
   );

   assign last = (k_ff == CNT_BITS'(WINDOW - 1));

   // operand selection for the shared compare unit
   always_comb begin
      cmp_a = head;
      cmp_b = x_ff;
      unique case (state_ff)
         ST_DIR: begin
            cmp_a = x_ff;
            cmp_b = oldest;
         end
         ST_HEAD: begin
            cmp_a = head;
            cmp_b = oldest;
         end
         ST_SWEEP: begin
            if (up_ff) begin
               cmp_a = next;
               cmp_b = (phase_ff == PH_PRE) ? oldest : x_ff;
            end else if (phase_ff == PH_SHIFT) begin
               cmp_a = carry_ff;
               cmp_b = oldest;
            end else begin
               cmp_a = head;
               cmp_b = x_ff;
            end
         end
         default: begin
            cmp_a = head;
            cmp_b = x_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      up_in        = up_ff;
      k_in         = k_ff;
      x_in         = x_ff;
      carry_in     = carry_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      win_ctrl     = '0;
      sort_tail    = head;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               x_in     = req_tdata[SAMPLE_BITS-1:0];
               state_in = ST_DIR;
            end
         end
         ST_DIR: begin
            // new sample at or above the oldest: the gap moves towards the tail
            up_in    = !cmp_res.lt;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            k_in     = '0;
            phase_in = (up_ff && cmp_res.eq) ? PH_SHIFT : PH_PRE;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            win_ctrl.rotate = 1'b1;
            carry_in        = head;
            if (up_ff) begin
               unique case (phase_ff)
                  PH_PRE: begin
                     sort_tail = head;
                     if (!last && cmp_res.eq) begin
                        phase_in = PH_SHIFT;
                     end
                  end
                  PH_SHIFT: begin
                     // pull the next entry in while it is still below the sample
                     if (!last && cmp_res.lt) begin
                        sort_tail = next;
                     end else begin
                        sort_tail = x_ff;
                        phase_in  = PH_POST;
                     end
                  end
                  default: begin
                     sort_tail = head;
                  end
               endcase
            end else begin
               unique case (phase_ff)
                  PH_PRE: begin
                     if (cmp_res.lt) begin
                        sort_tail = head;
                     end else begin
                        sort_tail = x_ff;
                        phase_in  = PH_SHIFT;
                     end
                  end
                  PH_SHIFT: begin
                     // entries lag one place until the oldest sample has gone by
                     if (cmp_res.eq) begin
                        sort_tail = head;
                        phase_in  = PH_POST;
                     end else begin
                        sort_tail = carry_ff;
                     end
                  end
                  default: begin
                     sort_tail = head;
                  end
               endcase
            end
            if (last) begin
               win_ctrl.ring_push = 1'b1;
               state_in           = ST_EMIT;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mid;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_PRE;
         up_ff        <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         up_ff        <= up_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      carry_ff    <= carry_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(unsigned'(rsp_data_ff));

endmodule
`default_nettype wire

/* design/mmf_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mmf_cmp - shared signed compare unit
// Gives a < b and a == b for two's complement samples.
// ---------------------------------------------------------------------------
module mmf_cmp #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic signed [SAMPLE_BITS-1:0] a,
   input  wire logic signed [SAMPLE_BITS-1:0] b,
   output mmf_pkg::mmf_cmp_res_type           res
);
   import mmf_pkg::*;

   always_comb begin
      res.lt = (a < b);
      res.eq = (a == b);
   end

endmodule
`default_nettype wire

/* design/mmf_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mmf_window - sorted row and arrival ring
// Both stores are shift lines; the sorted row rotates through its head
// during a sweep, the ring always holds the oldest sample at its head.
// ---------------------------------------------------------------------------
module mmf_window #(
   parameter int WINDOW      = 5,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mmf_pkg::mmf_win_ctrl_type     ctrl,
   input  wire logic signed [SAMPLE_BITS-1:0] sort_tail,
   input  wire logic signed [SAMPLE_BITS-1:0] ring_tail,
   output logic signed [SAMPLE_BITS-1:0]      head,
   output logic signed [SAMPLE_BITS-1:0]      next,
   output logic signed [SAMPLE_BITS-1:0]      oldest,
   output logic signed [SAMPLE_BITS-1:0]      mid
);
   import mmf_pkg::*;

   logic signed [SAMPLE_BITS-1:0] sorted_ff [WINDOW];
   logic signed [SAMPLE_BITS-1:0] sorted_in [WINDOW];
   logic signed [SAMPLE_BITS-1:0] ring_ff   [WINDOW];
   logic signed [SAMPLE_BITS-1:0] ring_in   [WINDOW];

   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         sorted_in[i] = sorted_ff[i];
         ring_in[i]   = ring_ff[i];
      end
      if (ctrl.rotate) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            sorted_in[i] = sorted_ff[i+1];
         end
         sorted_in[WINDOW-1] = sort_tail;
      end
      if (ctrl.ring_push) begin
         for (int i = 0; i < WINDOW - 1; i++) begin
            ring_in[i] = ring_ff[i+1];
         end
         ring_in[WINDOW-1] = ring_tail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            sorted_ff[i] <= '0;
            ring_ff[i]   <= '0;
         end
      end else begin
         for (int i = 0; i < WINDOW; i++) begin
            sorted_ff[i] <= sorted_in[i];
            ring_ff[i]   <= ring_in[i];
         end
      end
   end

   assign head   = sorted_ff[0];
   assign next   = sorted_ff[1];
   assign oldest = ring_ff[0];
   assign mid    = sorted_ff[WINDOW/2];

endmodule
`default_nettype wire

/* dv/moving_median_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// moving_median_checker - scoreboard for the moving median filter
// Keeps its own sorted window and arrival ring, predicts the median of every
// accepted sample beat and compares each result beat against the oldest
// expected median in order.
// ---------------------------------------------------------------------------
module moving_median_checker #(
   parameter int WINDOW      = 5,
   parameter int SAMPLE_BITS = 16,
   parameter int DATA_W      = 8*((SAMPLE_BITS+7)/8)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // fields from bit 0: sample
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [DATA_W-1:0] rsp_tdata,   // fields from bit 0: median
   output int                fail_count,
   output int                pending_count,
   output int                median_count
);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   sample_type  sorted_win [WINDOW];
   sample_type  arrival    [WINDOW];
   int unsigned oldest_idx;
   sample_type  median_q   [$];

   // drop the oldest sample from the sorted row, merge the new one in
   task automatic slide_window(input sample_type x, output sample_type med);
      sample_type oldest;
      int         drop_at;
      int         put_at;
      int         i;
      bit         found;
      oldest  = arrival[oldest_idx];
      drop_at = WINDOW - 1;
      found   = 1'b0;
      for (i = 0; i < WINDOW; i++) begin
         if (!found && sorted_win[i] == oldest) begin
            drop_at = i;
            found   = 1'b1;
         end
      end
      for (i = drop_at; i < WINDOW - 1; i++)
         sorted_win[i] = sorted_win[i+1];
      // first place among the remaining entries where x fits
      put_at = WINDOW - 1;
      found  = 1'b0;
      for (i = 0; i < WINDOW - 1; i++) begin
         if (!found && x <= sorted_win[i]) begin
            put_at = i;
            found  = 1'b1;
         end
      end
      for (i = WINDOW - 1; i > put_at; i--)
         sorted_win[i] = sorted_win[i-1];
      sorted_win[put_at]  = x;
      arrival[oldest_idx] = x;
      oldest_idx          = (oldest_idx + 1) % WINDOW;
      med                 = sorted_win[WINDOW/2];
   endtask

   always @(posedge clock) begin : watch_beats
      sample_type med;
      sample_type got;
      sample_type want;
      if (reset) begin
         for (int k = 0; k < WINDOW; k++) begin
            sorted_win[k] = '0;
            arrival[k]    = '0;
         end
         oldest_idx = 0;
         median_q.delete();
      end else begin
         // result side first, so a beat can never match its own sample
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[SAMPLE_BITS-1:0];
            if (median_q.size() == 0) begin
               $error("median: no result expected, actual %0d", got);
               fail_count++;
            end else begin
               want = median_q.pop_front();
               median_count++;
               if (got !== want) begin
                  $error("median mismatch: expected %0d, actual %0d", want, got);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            slide_window(sample_type'(req_tdata[SAMPLE_BITS-1:0]), med);
            median_q = {median_q, med};
         end
      end
      pending_count = median_q.size();
   end

endmodule

/* dv/tb_moving_median_filter.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_moving_median_filter - testbench for the moving median filter
// Drives sample beats (corner values, duplicate runs, drifting signals with
// impulse spikes, wide random data) under random idle and back-pressure,
// including one long output hold-off; the checker predicts every median.
// ---------------------------------------------------------------------------
module tb_moving_median_filter;

   localparam int WINDOW       = 5;
   localparam int SAMPLE_BITS  = 16;
   localparam int DATA_W       = 8*((SAMPLE_BITS+7)/8);
   localparam int PHASES       = 7;
   localparam int PHASE_ITEMS  = 250;
   localparam int LONG_HOLD    = 300;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 30;
   localparam int N_DIRECTED   = 21;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef enum int {MIX_WIDE, MIX_NARROW, MIX_DRIFT, MIX_CORNER} mix_type;

   localparam sample_type MAX_S = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type MIN_S = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;   // fields from bit 0: sample
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;         // fields from bit 0: median

   int         fail_count;
   int         pending_count;
   int         median_count;
   int         gap_pct        = 0;
   int         stall_pct      = 0;
   bit         long_hold_req  = 1'b0;
   bit         long_hold_done = 1'b0;
   int         samples_sent   = 0;
   int         quiet_cycles   = 0;
   sample_type walk_level     = '0;

   // start-up zeros, both extremes, runs of equal values, alternating bits
   sample_type directed_set [N_DIRECTED] = '{
      5, -5, MAX_S, MIN_S, MAX_S,
      MIN_S, MIN_S, MIN_S, MAX_S, MAX_S, MAX_S,
      7, 7, 7, 7, 7, 7,
      -1, 1, 16'h5555, 16'hAAAA
   };

   moving_median_filter #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   moving_median_checker #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .DATA_W      (DATA_W)
   ) median_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .median_count  (median_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic sample_type pick_sample(input mix_type mix);
      sample_type v;
      case (mix)
         MIX_NARROW: begin
            v = sample_type'(int'($urandom_range(0, 6)) - 3);
         end
         MIX_DRIFT: begin
            // slow wander with the odd impulse, as a median filter sees it
            walk_level = walk_level + sample_type'(int'($urandom_range(0, 64)) - 32);
            if ($urandom_range(0, 7) == 0)
               v = $urandom_range(0, 1) ? MAX_S : MIN_S;
            else
               v = walk_level;
         end
         MIX_CORNER: begin
            case ($urandom_range(0, 7))
               0: v = MIN_S;
               1: v = MAX_S;
               2: v = sample_type'(MIN_S + 1);
               3: v = sample_type'(MAX_S - 1);
               4: v = sample_type'(-1);
               5: v = sample_type'(0);
               6: v = sample_type'(1);
               default: v = sample_type'($urandom);
            endcase
         end
         default: begin
            v = sample_type'($urandom);
         end
      endcase
      return v;
   endfunction

   task automatic send_sample(input sample_type value);
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'($unsigned(value));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold_req && !long_hold_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_done = 1'b1;
            rsp_tready <= 1'b1;
         end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d medians outstanding",
                  quiet_cycles, pending_count);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      mix_type phase_mix;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      gap_pct   = 20;
      stall_pct = 20;
      for (int i = 0; i < N_DIRECTED; i++)
         send_sample(directed_set[i]);

      for (int phase = 0; phase < PHASES; phase++) begin
         phase_mix = mix_type'(phase % 4);
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 30; stall_pct = 30; end
            2: begin gap_pct = 15; stall_pct = 50; end
            3: begin
               // full-rate offer against a long hold-off fills the pipe
               gap_pct       = 0;
               stall_pct     = 20;
               long_hold_req = 1'b1;
            end
            4: begin gap_pct = 50; stall_pct = 10; end
            5: begin gap_pct = 10; stall_pct = 25; end
            default: begin gap_pct = 0; stall_pct = 0; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 9) < 7)
               send_sample(pick_sample(phase_mix));
            else
               send_sample(pick_sample(mix_type'($urandom_range(0, 3))));
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d sample beats sent (corners, equal runs, spiky drift, wide random),",
               samples_sent);
      $display("%0d medians checked under idle bursts and a %0d-cycle output hold-off",
               median_count, LONG_HOLD);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/mmf_pkg.sv
design/mmf_cmp.sv
design/mmf_window.sv
design/moving_median_filter.sv
dv/moving_median_checker.sv
dv/tb_moving_median_filter.sv
